[rtl/core/rau_pkg.sv]
package rau_pkg;

   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int NUM_W = 34;
   localparam int DEN_W = 31;
   localparam int CMD_W = 4;

   localparam logic [CMD_W-1:0] CMD_ADD = 4'd0;
   localparam logic [CMD_W-1:0] CMD_SUB = 4'd1;
   localparam logic [CMD_W-1:0] CMD_MUL = 4'd2;
   localparam logic [CMD_W-1:0] CMD_DIV = 4'd3;
   localparam logic [CMD_W-1:0] CMD_EQ  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_NE  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_GT  = 4'd6;
   localparam logic [CMD_W-1:0] CMD_LT  = 4'd7;
   localparam logic [CMD_W-1:0] CMD_LE  = 4'd8;
   localparam logic [CMD_W-1:0] CMD_GE  = 4'd9;
   localparam logic [CMD_W-1:0] CMD_INC = 4'd10;
   localparam logic [CMD_W-1:0] CMD_DEC = 4'd11;

endpackage

[rtl/core/rau_if.sv]
interface rau_req_if import rau_pkg::*; #(parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF);
   logic                            valid;
   logic                            ready;
   logic        [CMD_W-1:0]         cmd;
   logic signed [OPERAND_WIDTH-1:0] a_num;
   logic signed [OPERAND_WIDTH-1:0] a_den;
   logic signed [OPERAND_WIDTH-1:0] b_num;
   logic signed [OPERAND_WIDTH-1:0] b_den;

   modport source(output valid, cmd, a_num, a_den, b_num, b_den, input ready);
   modport sink(input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if import rau_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [NUM_W-1:0] res_num;
   logic        [DEN_W-1:0] res_den;
   logic                    cmp_true;
   logic                    error;

   modport source(output valid, res_num, res_den, cmp_true, error, input ready);
   modport sink(input valid, res_num, res_den, cmp_true, error, output ready);
endinterface

[rtl/core/rau_div.sv]
module rau_div import rau_pkg::*; #(
   parameter int WIDTH = 2 * OPERAND_WIDTH_DEF + 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH:0]   rem_ff;
   logic [WIDTH-1:0] quo_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [WIDTH:0] shifted;
   logic           fits;

   // restoring division, one quotient bit per cycle
   assign shifted = {rem_ff[WIDTH-1:0], quo_ff[WIDTH-1]};
   assign fits    = shifted >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CW'(1));
         if (start) begin
            rem_ff  <= '0;
            quo_ff  <= dividend;
            cnt_ff  <= CW'(WIDTH);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? shifted - {1'b0, divisor} : shifted;
            quo_ff <= {quo_ff[WIDTH-2:0], fits};
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/core/rational_arithmetic_unit.sv]
// Rational arithmetic unit: exact add, sub, mul, div, compare and inc/dec of
// two signed fractions, with results reduced to lowest terms.
// Request channel (req_if): opcode plus A and B as numerator/denominator
// pairs. Response channel (rsp_if): reduced numerator, positive
// denominator, compare flag and error flag. One word out per word in.
// Only one word is in flight: req_if.ready is high only while the core is
// idle. From accept, errors and unused opcodes go straight to the output;
// compares run the three products, then the compare; arithmetic runs
// form, sign fix, binary GCD and two iterative divisions, after the
// products for all but inc/dec. The next word can be taken in the cycle
// after the response is loaded. The binary GCD subtractor and the
// bit-serial divider dominate the arithmetic path; one shared multiplier
// forms the three cross products. Sync reset drops the response valid and
// returns the core to idle. A finished word sits in the output register
// until rsp_if.ready; the core takes the next request meanwhile and stalls
// only when a second result is ready before the first is taken.
module rational_arithmetic_unit import rau_pkg::*; #(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input logic      clock,
   input logic      reset,
   rau_req_if.sink  req_if,
   rau_rsp_if.source rsp_if
);

   localparam int W  = OPERAND_WIDTH;
   localparam int OW = W + 1;
   localparam int DW = (2 * W + 2 > 64) ? 64 : 2 * W + 2;
   localparam int KW = $clog2(DW + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_MUL, ST_CMP, ST_FORM, ST_NORM, ST_GCD, ST_DIV1,
      ST_DIV2, ST_OUT
   } state_type;

   state_type state_ff;

   logic        [CMD_W-1:0] cmd_ff;
   logic signed [W-1:0]     an_ff, ad_ff, bn_ff, bd_ff;
   logic        [1:0]       mcnt_ff;
   logic signed [DW-1:0]    p1_ff, p2_ff, p3_ff;
   logic        [DW-1:0]    n_ff, d_ff, mag_ff, u_ff, v_ff, g_ff, q1_ff;
   logic                    nneg_ff;
   logic        [KW-1:0]    k_ff;
   logic                    start_ff;

   logic signed [NUM_W-1:0] rn_ff;
   logic        [DEN_W-1:0] rd_ff;
   logic                    rc_ff, re_ff;

   logic                    rsp_valid_ff;
   logic signed [NUM_W-1:0] rsp_num_ff;
   logic        [DEN_W-1:0] rsp_den_ff;
   logic                    rsp_cmp_ff, rsp_err_ff;

   // sign-normalized operands
   logic signed [OW-1:0] an_x, ad_x, bn_x, bd_x, an_s, ad_s, bn_s, bd_s;
   assign an_x = OW'(an_ff);
   assign ad_x = OW'(ad_ff);
   assign bn_x = OW'(bn_ff);
   assign bd_x = OW'(bd_ff);
   assign an_s = ad_ff[W-1] ? -an_x : an_x;
   assign ad_s = ad_ff[W-1] ? -ad_x : ad_x;
   assign bn_s = bd_ff[W-1] ? -bn_x : bn_x;
   assign bd_s = bd_ff[W-1] ? -bd_x : bd_x;

   // shared multiplier: an*bd (an*bn for mul), then bn*ad, then ad*bd
   logic signed [OW-1:0]   op_a, op_b;
   logic signed [2*OW-1:0] prod;
   logic signed [DW-1:0]   prod_d;
   always_comb begin
      case (mcnt_ff)
         2'd0: begin
            op_a = an_s;
            op_b = (cmd_ff == CMD_MUL) ? bn_s : bd_s;
         end
         2'd1: begin
            op_a = bn_s;
            op_b = ad_s;
         end
         default: begin
            op_a = ad_s;
            op_b = bd_s;
         end
      endcase
   end
   assign prod   = op_a * op_b;
   assign prod_d = DW'(prod);

   // numerator and denominator before reduction
   logic [DW-1:0] n_c, d_c, an_d, ad_d;
   assign an_d = DW'(an_s);
   assign ad_d = DW'(ad_s);
   always_comb begin
      case (cmd_ff)
         CMD_ADD: begin n_c = p1_ff + p2_ff; d_c = p3_ff; end
         CMD_SUB: begin n_c = p1_ff - p2_ff; d_c = p3_ff; end
         CMD_MUL: begin n_c = p1_ff;         d_c = p3_ff; end
         CMD_DIV: begin n_c = p1_ff;         d_c = p2_ff; end
         CMD_INC: begin n_c = an_d + ad_d;   d_c = ad_d;  end
         default: begin n_c = an_d - ad_d;   d_c = ad_d;  end
      endcase
   end

   // denominator sign fix, then magnitude of numerator
   logic [DW-1:0] nt, dt, mag_c;
   assign nt    = d_ff[DW-1] ? -n_ff : n_ff;
   assign dt    = d_ff[DW-1] ? -d_ff : d_ff;
   assign mag_c = nt[DW-1] ? -nt : nt;

   logic cmp_c;
   always_comb begin
      case (cmd_ff)
         CMD_EQ:  cmp_c = p1_ff == p2_ff;
         CMD_NE:  cmp_c = p1_ff != p2_ff;
         CMD_GT:  cmp_c = p1_ff >  p2_ff;
         CMD_LT:  cmp_c = p1_ff <  p2_ff;
         CMD_LE:  cmp_c = p1_ff <= p2_ff;
         default: cmp_c = p1_ff >= p2_ff;
      endcase
   end

   logic bad_den;
   assign bad_den = (ad_ff == '0) || (cmd_ff < CMD_INC && bd_ff == '0) ||
                    (cmd_ff == CMD_DIV && bn_ff == '0);

   // divider shared by both reductions
   logic          div_done;
   logic [DW-1:0] div_q, div_a;
   assign div_a = (state_ff == ST_DIV2) ? d_ff : mag_ff;

   rau_div #(.WIDTH(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (div_a),
      .divisor  (g_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   logic signed [DW-1:0] num_s;
   logic signed [63:0]   num64;
   logic        [63:0]   den64;
   assign num_s = nneg_ff ? -q1_ff : q1_ff;
   assign num64 = 64'(num_s);
   assign den64 = 64'(div_q);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_OUT the output register is reloaded below
         if (rsp_valid_ff && rsp_if.ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  cmd_ff   <= req_if.cmd;
                  an_ff    <= req_if.a_num;
                  ad_ff    <= req_if.a_den;
                  bn_ff    <= req_if.b_num;
                  bd_ff    <= req_if.b_den;
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               rn_ff   <= '0;
               rd_ff   <= DEN_W'(1);
               rc_ff   <= 1'b0;
               re_ff   <= 1'b0;
               mcnt_ff <= 2'd0;
               if (cmd_ff > CMD_DEC) begin
                  state_ff <= ST_OUT;
               end else if (bad_den) begin
                  re_ff    <= 1'b1;
                  state_ff <= ST_OUT;
               end else if (cmd_ff == CMD_INC || cmd_ff == CMD_DEC) begin
                  state_ff <= ST_FORM;
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               mcnt_ff <= mcnt_ff + 2'd1;
               case (mcnt_ff)
                  2'd0:    p1_ff <= prod_d;
                  2'd1:    p2_ff <= prod_d;
                  default: p3_ff <= prod_d;
               endcase
               if (mcnt_ff == 2'd2) begin
                  state_ff <= (cmd_ff >= CMD_EQ && cmd_ff <= CMD_GE) ? ST_CMP : ST_FORM;
               end
            end
            ST_CMP: begin
               rc_ff    <= cmp_c;
               state_ff <= ST_OUT;
            end
            ST_FORM: begin
               n_ff     <= n_c;
               d_ff     <= d_c;
               state_ff <= ST_NORM;
            end
            ST_NORM: begin
               nneg_ff  <= nt[DW-1];
               mag_ff   <= mag_c;
               d_ff     <= dt;
               u_ff     <= mag_c;
               v_ff     <= dt;
               k_ff     <= '0;
               state_ff <= ST_GCD;
            end
            ST_GCD: begin
               // binary GCD, one shift or subtract per cycle
               if (u_ff == '0 || v_ff == '0) begin
                  g_ff     <= (u_ff | v_ff) << k_ff;
                  start_ff <= 1'b1;
                  state_ff <= ST_DIV1;
               end else if (!u_ff[0] && !v_ff[0]) begin
                  u_ff <= u_ff >> 1;
                  v_ff <= v_ff >> 1;
                  k_ff <= k_ff + KW'(1);
               end else if (!u_ff[0]) begin
                  u_ff <= u_ff >> 1;
               end else if (!v_ff[0]) begin
                  v_ff <= v_ff >> 1;
               end else if (u_ff >= v_ff) begin
                  u_ff <= u_ff - v_ff;
               end else begin
                  v_ff <= v_ff - u_ff;
               end
            end
            ST_DIV1: begin
               if (div_done) begin
                  q1_ff    <= div_q;
                  start_ff <= 1'b1;
                  state_ff <= ST_DIV2;
               end else begin
                  start_ff <= 1'b0;
               end
            end
            ST_DIV2: begin
               if (div_done) begin
                  rn_ff    <= num64[NUM_W-1:0];
                  rd_ff    <= den64[DEN_W-1:0];
                  state_ff <= ST_OUT;
               end else begin
                  start_ff <= 1'b0;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_num_ff   <= rn_ff;
                  rsp_den_ff   <= rd_ff;
                  rsp_cmp_ff   <= rc_ff;
                  rsp_err_ff   <= re_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_if.ready    = (state_ff == ST_IDLE);
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.res_num  = rsp_num_ff;
   assign rsp_if.res_den  = rsp_den_ff;
   assign rsp_if.cmp_true = rsp_cmp_ff;
   assign rsp_if.error    = rsp_err_ff;

endmodule
